// ----- sv/seml_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared sizes, register indexes and types of the RGB Sobel edge block.
// ----------------------------------------------------------------------------
package seml_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 16;
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int LANES      = 3;
    localparam int MAG_W      = 8;
    localparam int OCOL_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WID_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [HGT_W-1:0] RST_HEIGHT = 16'd480;

    typedef struct packed {
        logic [HGT_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              run_last;
        logic              frame_last;
    } t_meta;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } t_lane_st;

    typedef logic [8:0][7:0] t_chan_win;

endpackage

// ----- sv/seml_if.sv -----
// ----------------------------------------------------------------------------
// Sobel edge stream interfaces
// Valid/ready channels for incoming pixel words and outgoing result words.
// ----------------------------------------------------------------------------
interface seml_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, mode, pixel_red, pixel_green, pixel_blue, input ready);
    modport sink   (input valid, mode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface seml_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  edge_red;
    logic [7:0]  edge_green;
    logic [7:0]  edge_blue;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic        run_last;
    logic        frame_last;

    modport source (output valid, edge_red, edge_green, edge_blue, out_row, out_col,
                    run_last, frame_last, input ready);
    modport sink   (input valid, edge_red, edge_green, edge_blue, out_row, out_col,
                    run_last, frame_last, output ready);
endinterface

// ----- sv/sobel_edge_magnitude_rgb.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streams raster pixels through two line stores and a 3x3 window and gives
// the rounded, clamped Sobel gradient magnitude of every pixel per channel.
// ----------------------------------------------------------------------------
// A word is taken only once the last one is done, and each result it
// releases waits on the twelve-step square-root iteration in each channel
// lane, which runs only while the output register is empty. Three lanes
// work on the red, green and blue channels side by side. Words that arrive
// out of place (a flush before the frame is in, a pixel while the last row
// drains) are taken and dropped.
module sobel_edge_magnitude_rgb (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [seml_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [seml_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    seml_in_if.sink                            i_px,
    seml_out_if.source                         o_res
);
    import seml_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FCAP = 3'd3;
    localparam logic [2:0] S_GO   = 3'd4;
    localparam logic [2:0] S_CALC = 3'd5;

    logic [2:0]             r_state;
    logic [WID_W-1:0]       r_fw;
    logic [HGT_W-1:0]       r_fh;
    logic [COL_W-1:0]       r_col;
    logic [HGT_W-1:0]       r_row;
    logic [COL_W:0]         r_drain;
    logic [PIX_W-1:0]       r_win [3][3];
    logic [PIX_W-1:0]       r_cw  [3][3];
    logic [PIX_W-1:0]       r_px;
    logic [1:0]             r_k;
    logic                   r_fv;
    logic                   r_do_b;
    t_meta                  r_meta;
    t_meta                  r_mb;

    logic [COL_W:0]         eff_w;
    logic [HGT_W-1:0]       eff_h;
    logic [PIX_W-1:0]       n_win [3][3];
    logic [PIX_W-1:0]       tmp   [3][3];
    logic [PIX_W-1:0]       top, mid;
    logic [PIX_W-1:0]       old_rd, new_rd;
    logic [COL_W+1:0]       col_k;
    logic                   fv_k;
    logic [COL_W-1:0]       raddr;
    logic                   we;
    logic                   last_c, last_d;
    logic                   start;
    logic                   full;
    t_chan_win [2:0]        lane_win;
    t_lane_st  [2:0]        lane_st;

    always_comb begin
        if (r_fw == '0) begin
            eff_w = (COL_W+1)'(1);
        end else if (r_fw > WID_W'(MAX_WIDTH)) begin
            eff_w = (COL_W+1)'(MAX_WIDTH);
        end else begin
            eff_w = (COL_W+1)'(r_fw);
        end
        eff_h  = (r_fh == '0) ? HGT_W'(1) : r_fh;
        last_c = ((COL_W+1)'(r_col) + (COL_W+1)'(1)) >= eff_w;
        last_d = (r_drain + (COL_W+1)'(1)) >= eff_w;
        col_k  = (COL_W+2)'(r_drain) + (COL_W+2)'(r_k) - (COL_W+2)'(1);
        fv_k   = !((r_drain == '0) && (r_k == 2'd0)) && (col_k < (COL_W+2)'(eff_w));
        raddr  = (r_state == S_FRD) ? col_k[COL_W-1:0] : r_col;
        we     = (r_state == S_PRD);
        top    = (r_row >= HGT_W'(2)) ? old_rd : '0;
        mid    = (r_row >= HGT_W'(1)) ? new_rd : '0;
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = (r_col == '0) ? '0 : r_win[i][1];
            n_win[i][1] = (r_col == '0) ? '0 : r_win[i][2];
            tmp[i][0]   = r_win[i][1];
            tmp[i][1]   = r_win[i][2];
            tmp[i][2]   = '0;
        end
        n_win[0][2] = top;
        n_win[1][2] = mid;
        n_win[2][2] = r_px;
        for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < 9; j++) begin
                lane_win[l][j] = r_cw[j/3][j%3][PIX_W-1-8*l -: 8];
            end
        end
        start = (r_state == S_GO) && !full;
    end

    assign i_px.ready = (r_state == S_IDLE);

    seml_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_col),
        .i_wdata (new_rd),
        .i_raddr (raddr),
        .o_rdata (old_rd)
    );

    seml_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_col),
        .i_wdata (r_px),
        .i_raddr (raddr),
        .o_rdata (new_rd)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        seml_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (start),
            .i_win   (lane_win[l]),
            .o_st    (lane_st[l])
        );
    end

    seml_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lanes (lane_st),
        .i_meta  (r_meta),
        .o_full  (full),
        .o_res   (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fw    <= RST_WIDTH;
            r_fh    <= RST_HEIGHT;
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
            r_do_b  <= 1'b0;
            r_k     <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[WID_W-1:0];
                    CFG_FRAME_HEIGHT: r_fh <= i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_px.valid && (i_px.mode ? (r_row >= eff_h) : (r_row < eff_h))) begin
                        r_px <= {i_px.pixel_red, i_px.pixel_green, i_px.pixel_blue};
                        r_k  <= 2'd0;
                        r_state <= i_px.mode ? S_FRD : S_PRD;
                    end
                end
                S_PRD: begin
                    r_win <= n_win;
                    if (last_c) begin
                        r_col   <= '0;
                        r_row   <= r_row + HGT_W'(1);
                        r_drain <= '0;
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                    r_mb.row        <= r_row - HGT_W'(1);
                    r_mb.col        <= OCOL_W'(r_col);
                    r_mb.run_last   <= 1'b1;
                    r_mb.frame_last <= 1'b0;
                    if ((r_row >= HGT_W'(1)) && (r_col != '0)) begin
                        r_cw            <= n_win;
                        r_meta.row      <= r_row - HGT_W'(1);
                        r_meta.col      <= OCOL_W'(r_col - COL_W'(1));
                        r_meta.run_last <= !last_c;
                        r_meta.frame_last <= 1'b0;
                        r_do_b          <= last_c;
                        r_state         <= S_GO;
                    end else if ((r_row >= HGT_W'(1)) && last_c) begin
                        for (int i = 0; i < 3; i++) begin
                            r_cw[i][0] <= n_win[i][1];
                            r_cw[i][1] <= n_win[i][2];
                            r_cw[i][2] <= '0;
                        end
                        r_meta.row        <= r_row - HGT_W'(1);
                        r_meta.col        <= OCOL_W'(r_col);
                        r_meta.run_last   <= 1'b1;
                        r_meta.frame_last <= 1'b0;
                        r_do_b            <= 1'b0;
                        r_state           <= S_GO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FRD: begin
                    r_fv    <= fv_k;
                    r_state <= S_FCAP;
                end
                S_FCAP: begin
                    r_cw[0][r_k] <= (r_fv && (r_row >= HGT_W'(2))) ? old_rd : '0;
                    r_cw[1][r_k] <= r_fv ? new_rd : '0;
                    r_cw[2][r_k] <= '0;
                    if (r_k == 2'd2) begin
                        r_meta.row        <= r_row - HGT_W'(1);
                        r_meta.col        <= OCOL_W'(r_drain);
                        r_meta.run_last   <= 1'b1;
                        r_meta.frame_last <= last_d;
                        r_do_b            <= 1'b0;
                        if (last_d) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_drain <= '0;
                        end else begin
                            r_drain <= r_drain + (COL_W+1)'(1);
                        end
                        r_state <= S_GO;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_FRD;
                    end
                end
                S_GO: begin
                    if (!full) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (lane_st[0].done) begin
                        if (r_do_b) begin
                            r_cw    <= tmp;
                            r_meta  <= r_mb;
                            r_do_b  <= 1'b0;
                            r_state <= S_GO;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/seml_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module seml_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/seml_lane.sv -----
// ----------------------------------------------------------------------------
// Sobel lane
// Gradient sums, squares and a rounded integer square root for one channel.
// ----------------------------------------------------------------------------
module seml_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  seml_pkg::t_chan_win i_win,
    output seml_pkg::t_lane_st  o_st
);
    import seml_pkg::*;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_SQ   = 3'd1;
    localparam logic [2:0] L_SUM  = 3'd2;
    localparam logic [2:0] L_ROOT = 3'd3;
    localparam logic [2:0] L_FIX  = 3'd4;

    logic [2:0]         r_phase;
    logic               r_done;
    logic [MAG_W-1:0]   r_mag;
    logic signed [10:0] r_gx;
    logic signed [10:0] r_gy;
    logic [19:0]        r_sx;
    logic [19:0]        r_sy;
    logic [20:0]        r_s;
    logic [11:0]        r_n;
    logic [3:0]         r_bit;

    logic [10:0]        px, qx, py, qy;
    logic signed [21:0] sq_x, sq_y;
    logic [11:0]        t;
    logic [23:0]        tt;
    logic [24:0]        nn;
    logic [12:0]        n1;

    always_comb begin
        px   = 11'(i_win[2]) + {2'b0, i_win[5], 1'b0} + 11'(i_win[8]);
        qx   = 11'(i_win[0]) + {2'b0, i_win[3], 1'b0} + 11'(i_win[6]);
        py   = 11'(i_win[6]) + {2'b0, i_win[7], 1'b0} + 11'(i_win[8]);
        qy   = 11'(i_win[0]) + {2'b0, i_win[1], 1'b0} + 11'(i_win[2]);
        sq_x = r_gx * r_gx;
        sq_y = r_gy * r_gy;
        t    = r_n | (12'd1 << r_bit);
        tt   = t * t;
        nn   = 25'(r_n * r_n) + 25'(r_n);
        n1   = ({4'b0, r_s} > nn) ? 13'(r_n) + 13'd1 : 13'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                L_IDLE: begin
                    if (i_start) begin
                        r_gx    <= $signed(px - qx);
                        r_gy    <= $signed(py - qy);
                        r_phase <= L_SQ;
                    end
                end
                L_SQ: begin
                    r_sx    <= sq_x[19:0];
                    r_sy    <= sq_y[19:0];
                    r_phase <= L_SUM;
                end
                L_SUM: begin
                    r_s     <= 21'(r_sx) + 21'(r_sy);
                    r_n     <= '0;
                    r_bit   <= 4'd11;
                    r_phase <= L_ROOT;
                end
                L_ROOT: begin
                    if (tt <= {3'b0, r_s}) begin
                        r_n <= t;
                    end
                    if (r_bit == 4'd0) begin
                        r_phase <= L_FIX;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
                L_FIX: begin
                    r_mag   <= (n1 > 13'd255) ? 8'd255 : n1[7:0];
                    r_done  <= 1'b1;
                    r_phase <= L_IDLE;
                end
                default: r_phase <= L_IDLE;
            endcase
        end
    end

    assign o_st.done = r_done;
    assign o_st.mag  = r_mag;
endmodule

// ----- sv/seml_merge.sv -----
// ----------------------------------------------------------------------------
// Sobel result merge
// Joins the three lane magnitudes with the position into one output word.
// ----------------------------------------------------------------------------
module seml_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  seml_pkg::t_lane_st [2:0]      i_lanes,
    input  seml_pkg::t_meta               i_meta,
    output logic                          o_full,
    seml_out_if.source                    o_res
);
    import seml_pkg::*;

    logic       r_valid;
    logic [7:0] r_red, r_green, r_blue;
    t_meta      r_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_lanes[0].done) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lanes[0].done) begin
            r_red   <= i_lanes[0].mag;
            r_green <= i_lanes[1].mag;
            r_blue  <= i_lanes[2].mag;
            r_meta  <= i_meta;
        end
    end

    assign o_full           = r_valid;
    assign o_res.valid      = r_valid;
    assign o_res.edge_red   = r_red;
    assign o_res.edge_green = r_green;
    assign o_res.edge_blue  = r_blue;
    assign o_res.out_row    = r_meta.row;
    assign o_res.out_col    = r_meta.col;
    assign o_res.run_last   = r_meta.run_last;
    assign o_res.frame_last = r_meta.frame_last;
endmodule
